/* sv/acr_pkg.sv */
// package for the arc center block
// holds the pipeline control struct shared by the cells and the top level
`default_nettype none

package acr_pkg;

   typedef struct packed {
      logic en;      // pipeline advance
      logic valid;   // stage holds an item
   } acr_ctl_type;

endpackage

`default_nettype wire

/* sv/acr_sqrt_cell.sv */
// one digit step of two floor square roots, with the item's sideband
// depends on acr_pkg
`default_nettype none

module acr_sqrt_cell import acr_pkg::*; #(
   parameter int XW = 66,
   parameter int SIDE_W = 8,
   parameter int HW = XW / 2,
   parameter int RW = XW / 2 + 3
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire acr_ctl_type            up_ctl,
   input  wire logic [1:0][XW-1:0]     up_rad,
   input  wire logic [1:0][RW-1:0]     up_rem,
   input  wire logic [1:0][HW-1:0]     up_root,
   input  wire logic [SIDE_W-1:0]      up_side,
   output logic                        valid_ff,
   output logic [1:0][XW-1:0]          rad_ff,
   output logic [1:0][RW-1:0]          rem_ff,
   output logic [1:0][HW-1:0]          root_ff,
   output logic [SIDE_W-1:0]           side_ff
);

   logic [1:0][XW-1:0] rad_in;
   logic [1:0][RW-1:0] rem_in;
   logic [1:0][HW-1:0] root_in;
   logic [1:0][RW-1:0] cand;
   logic [1:0][RW-1:0] trial;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         cand[k]    = {up_rem[k][RW-3:0], up_rad[k][XW-1 -: 2]};
         trial[k]   = RW'({up_root[k], 2'b01});
         rad_in[k]  = {up_rad[k][XW-3:0], 2'b00};
         if (cand[k] >= trial[k]) begin
            rem_in[k]  = cand[k] - trial[k];
            root_in[k] = {up_root[k][HW-2:0], 1'b1};
         end else begin
            rem_in[k]  = cand[k];
            root_in[k] = {up_root[k][HW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ctl.en) begin
         valid_ff <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ctl.en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= up_side;
      end
   end

endmodule

`default_nettype wire

/* sv/acr_div_cell.sv */
// one quotient bit of two restoring divisions by a shared divisor
// depends on acr_pkg
`default_nettype none

module acr_div_cell import acr_pkg::*; #(
   parameter int NW = 67,
   parameter int DW = 34,
   parameter int QW = 33,
   parameter int IDX = 0,
   parameter int SIDE_W = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire acr_ctl_type            up_ctl,
   input  wire logic [1:0][NW-1:0]     up_rem,
   input  wire logic [1:0][QW-1:0]     up_quo,
   input  wire logic [DW-1:0]          up_div,
   input  wire logic [SIDE_W-1:0]      up_side,
   output logic                        valid_ff,
   output logic [1:0][NW-1:0]          rem_ff,
   output logic [1:0][QW-1:0]          quo_ff,
   output logic [DW-1:0]               div_ff,
   output logic [SIDE_W-1:0]           side_ff
);

   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [CW-1:0]      shifted;
   logic [1:0][CW-1:0] remx;
   logic [1:0][NW-1:0] rem_in;
   logic [1:0][QW-1:0] quo_in;

   always_comb begin
      shifted = CW'(up_div) << IDX;
      for (int k = 0; k < 2; k++) begin
         remx[k]   = CW'(up_rem[k]);
         quo_in[k] = up_quo[k];
         if (remx[k] >= shifted) begin
            rem_in[k]      = up_rem[k] - shifted[NW-1:0];
            quo_in[k][IDX] = 1'b1;
         end else begin
            rem_in[k] = up_rem[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ctl.en) begin
         valid_ff <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ctl.en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         div_ff  <= up_div;
         side_ff <= up_side;
      end
   end

endmodule

`default_nettype wire

/* sv/arc_center_from_radius.sv */
// arc center from two endpoints and a signed radius, top level
// depends on acr_pkg, acr_sqrt_cell, acr_div_cell
//
//   channel | ports        | handshake     | payload
//   req     | req_*        | valid / ready | start_x start_y end_x end_y radius
//   rsp     | rsp_*        | valid / ready | center_x center_y found
//
// one transfer per cycle while the output is not stalled; stages: front s1 and s2,
// a row of COORD_WIDTH+1 root cells, scale s4, a row of COORD_WIDTH+1 quotient cells,
// output register; all advance together whenever the output register is empty or taken
// a stalled output holds every stage; bubbles are not squeezed out
// reset clears the valid bits only
`default_nettype none

module arc_center_from_radius import acr_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_radius,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0]      rsp_center_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_center_y,
   output logic                               rsp_found
);

   localparam int W    = COORD_WIDTH;
   localparam int MW   = W + 1;
   localparam int LW   = 2 * W + 2;
   localparam int SW   = W + 1;
   localparam int RW   = W + 4;
   localparam int NW   = 2 * W + 3;
   localparam int DW   = W + 2;
   localparam int QW   = W + 1;
   localparam int TW   = (LW > 64) ? LW : 64;
   localparam int SIDE_S = 4 + 2 * (W + 1) + 2 * MW;
   localparam int SIDE_D = 4 + 2 * (W + 1);
   localparam logic [63:0] LTHR =
      ((64'd4 << (2 * FRAC_BITS)) + 64'd9999) / 64'd10000;
   localparam logic signed [W+3:0] HMAX = $signed({5'b00000, {(W-1){1'b1}}});
   localparam logic signed [W+3:0] HMIN = -HMAX - 1;

   logic en;

   // front: differences, magnitudes, sums
   logic signed [W:0] a_c, b_c, sx_c, sy_c;
   logic [MW-1:0]     ma_c, mb_c;
   logic [W-1:0]      rm_c;
   logic              plus_c;

   logic              s1_valid_ff;
   logic [MW-1:0]     s1_ma_ff, s1_mb_ff;
   logic [W-1:0]      s1_rm_ff;
   logic              s1_sa_ff, s1_sb_ff, s1_plus_ff;
   logic signed [W:0] s1_sx_ff, s1_sy_ff;

   logic              s2_valid_ff;
   logic [LW-1:0]     s2_aa_ff, s2_bb_ff;
   logic [2*W-1:0]    s2_rr_ff;
   logic [MW-1:0]     s2_ma_ff, s2_mb_ff;
   logic              s2_sa_ff, s2_sb_ff, s2_plus_ff;
   logic signed [W:0] s2_sx_ff, s2_sy_ff;

   logic [LW-1:0]     len_c, r4_c, d_c;
   logic [TW-1:0]     len_t;
   logic              found_c;

   always_comb begin
      a_c    = {req_start_y[W-1], req_start_y} - {req_end_y[W-1], req_end_y};
      b_c    = {req_end_x[W-1], req_end_x} - {req_start_x[W-1], req_start_x};
      sx_c   = {req_start_x[W-1], req_start_x} + {req_end_x[W-1], req_end_x};
      sy_c   = {req_start_y[W-1], req_start_y} + {req_end_y[W-1], req_end_y};
      ma_c   = a_c[W] ? MW'(-a_c) : MW'(a_c);
      mb_c   = b_c[W] ? MW'(-b_c) : MW'(b_c);
      rm_c   = req_radius[W-1] ? W'(-req_radius) : W'(req_radius);
      plus_c = req_radius[W-1] || (req_radius == '0);
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ma_ff   <= ma_c;
         s1_mb_ff   <= mb_c;
         s1_rm_ff   <= rm_c;
         s1_sa_ff   <= a_c[W];
         s1_sb_ff   <= b_c[W];
         s1_plus_ff <= plus_c;
         s1_sx_ff   <= sx_c;
         s1_sy_ff   <= sy_c;
         s2_aa_ff   <= s1_ma_ff * s1_ma_ff;
         s2_bb_ff   <= s1_mb_ff * s1_mb_ff;
         s2_rr_ff   <= s1_rm_ff * s1_rm_ff;
         s2_ma_ff   <= s1_ma_ff;
         s2_mb_ff   <= s1_mb_ff;
         s2_sa_ff   <= s1_sa_ff;
         s2_sb_ff   <= s1_sb_ff;
         s2_plus_ff <= s1_plus_ff;
         s2_sx_ff   <= s1_sx_ff;
         s2_sy_ff   <= s1_sy_ff;
      end
   end

   always_comb begin
      len_c   = s2_aa_ff + s2_bb_ff;
      r4_c    = LW'({s2_rr_ff, 2'b00});
      len_t   = TW'(len_c);
      found_c = (len_t >= TW'(LTHR)) && (r4_c >= len_c);
      d_c     = found_c ? (r4_c - len_c) : '0;
   end

   // row of root cells
   logic [SW:0]                    sq_valid;
   logic [SW:0][1:0][LW-1:0]       sq_rad;
   logic [SW:0][1:0][RW-1:0]       sq_rem;
   logic [SW:0][1:0][SW-1:0]       sq_root;
   logic [SW:0][SIDE_S-1:0]        sq_side;

   assign sq_valid[0]   = s2_valid_ff;
   assign sq_rad[0][0]  = d_c;
   assign sq_rad[0][1]  = len_c;
   assign sq_rem[0]     = '0;
   assign sq_root[0]    = '0;
   assign sq_side[0]    = {found_c, s2_plus_ff, s2_sa_ff, s2_sb_ff, s2_sx_ff, s2_sy_ff,
                           s2_ma_ff, s2_mb_ff};

   for (genvar g = 0; g < SW; g++) begin : g_sqrt
      acr_ctl_type ctl;
      assign ctl.en    = en;
      assign ctl.valid = sq_valid[g];
      acr_sqrt_cell #(.XW(LW), .SIDE_W(SIDE_S), .HW(SW), .RW(RW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_ctl   (ctl),
         .up_rad   (sq_rad[g]),
         .up_rem   (sq_rem[g]),
         .up_root  (sq_root[g]),
         .up_side  (sq_side[g]),
         .valid_ff (sq_valid[g+1]),
         .rad_ff   (sq_rad[g+1]),
         .rem_ff   (sq_rem[g+1]),
         .root_ff  (sq_root[g+1]),
         .side_ff  (sq_side[g+1])
      );
   end

   // scale stage
   logic              t_found, t_plus, t_sa, t_sb;
   logic signed [W:0] t_sx, t_sy;
   logic [MW-1:0]     t_ma, t_mb;

   assign {t_found, t_plus, t_sa, t_sb, t_sx, t_sy, t_ma, t_mb} = sq_side[SW];

   logic                  s4_valid_ff;
   logic [LW-1:0]         s4_px_ff, s4_py_ff;
   logic [SW-1:0]         s4_p_ff;
   logic [SIDE_D-1:0]     s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= sq_valid[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_px_ff   <= t_ma * sq_root[SW][0];
         s4_py_ff   <= t_mb * sq_root[SW][0];
         s4_p_ff    <= sq_root[SW][1];
         s4_side_ff <= {t_found, t_plus, t_sa, t_sb, t_sx, t_sy};
      end
   end

   // row of quotient cells
   logic [QW:0]                dv_valid;
   logic [QW:0][1:0][NW-1:0]   dv_rem;
   logic [QW:0][1:0][QW-1:0]   dv_quo;
   logic [QW:0][DW-1:0]        dv_div;
   logic [QW:0][SIDE_D-1:0]    dv_side;

   assign dv_valid[0]  = s4_valid_ff;
   assign dv_rem[0][0] = NW'({s4_px_ff, 1'b0}) + NW'(s4_p_ff);
   assign dv_rem[0][1] = NW'({s4_py_ff, 1'b0}) + NW'(s4_p_ff);
   assign dv_quo[0]    = '0;
   assign dv_div[0]    = {s4_p_ff, 1'b0};
   assign dv_side[0]   = s4_side_ff;

   for (genvar g = 0; g < QW; g++) begin : g_div
      acr_ctl_type ctl;
      assign ctl.en    = en;
      assign ctl.valid = dv_valid[g];
      acr_div_cell #(.NW(NW), .DW(DW), .QW(QW), .IDX(QW - 1 - g), .SIDE_W(SIDE_D)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_ctl   (ctl),
         .up_rem   (dv_rem[g]),
         .up_quo   (dv_quo[g]),
         .up_div   (dv_div[g]),
         .up_side  (dv_side[g]),
         .valid_ff (dv_valid[g+1]),
         .rem_ff   (dv_rem[g+1]),
         .quo_ff   (dv_quo[g+1]),
         .div_ff   (dv_div[g+1]),
         .side_ff  (dv_side[g+1])
      );
   end

   // final: signs, midpoint, rounding, saturation, zero center when not found
   logic              f_found, f_plus, f_sa, f_sb;
   logic signed [W:0] f_sx, f_sy;
   logic signed [W+3:0] ox, oy, vx, vy, hx, hy;
   logic [W-1:0]      cx_c, cy_c;

   assign {f_found, f_plus, f_sa, f_sb, f_sx, f_sy} = dv_side[QW];

   always_comb begin
      ox = $signed({3'b000, dv_quo[QW][0]});
      oy = $signed({3'b000, dv_quo[QW][1]});
      if (f_sa) begin
         ox = -ox;
      end
      if (f_sb) begin
         oy = -oy;
      end
      if (!f_plus) begin
         ox = -ox;
         oy = -oy;
      end
      vx = (W+4)'(f_sx) + ox + 1;
      vy = (W+4)'(f_sy) + oy + 1;
      hx = vx >>> 1;
      hy = vy >>> 1;
      if (hx > HMAX) begin
         cx_c = HMAX[W-1:0];
      end else if (hx < HMIN) begin
         cx_c = HMIN[W-1:0];
      end else begin
         cx_c = hx[W-1:0];
      end
      if (hy > HMAX) begin
         cy_c = HMAX[W-1:0];
      end else if (hy < HMIN) begin
         cy_c = HMIN[W-1:0];
      end else begin
         cy_c = hy[W-1:0];
      end
      if (!f_found) begin
         cx_c = '0;
         cy_c = '0;
      end
   end

   logic          rsp_valid_ff, rsp_found_ff;
   logic [W-1:0]  rsp_cx_ff, rsp_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_cx_ff    <= cx_c;
         rsp_cy_ff    <= cy_c;
         rsp_found_ff <= f_found;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_center_x = $signed(rsp_cx_ff);
   assign rsp_center_y = $signed(rsp_cy_ff);
   assign rsp_found    = rsp_found_ff;

endmodule

`default_nettype wire

/* sv/acr_checker.sv */
// port-level checks for the arc center block, bound to the top level
// depends on arc_center_from_radius
`default_nettype none

module acr_checker #(
   parameter int COORD_WIDTH = 32
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [COORD_WIDTH-1:0] rsp_center_x,
   input wire logic [COORD_WIDTH-1:0] rsp_center_y,
   input wire logic                   rsp_found
);

   // no center means zero coordinates
   a_zero_when_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_center_x == '0 && rsp_center_y == '0)
      else $error("center not zero without found");

   // input side stalls only behind a held result
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not track the output register");

   // nothing comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_center_x)
         && $stable(rsp_center_y) && $stable(rsp_found))
      else $error("stalled result changed");

endmodule

bind arc_center_from_radius acr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_acr_checker (.*);

`default_nettype wire

/* verif/arc_center_from_radius_tb.sv */
// testbench for arc_center_from_radius: drives arc commands through the valid/ready
// request channel and checks each center result against an in-bench predictor
// depends on acr_pkg and arc_center_from_radius
`timescale 1ns / 100ps

module arc_center_from_radius_tb;
   import acr_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int LATENCY = CW * 2 + 6;
   localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
   localparam longint CMIN = -CMAX - 1;
   localparam logic [127:0] CHORD_MIN = ((128'd4 << (2 * FB)) + 128'd9999) / 128'd10000;

   typedef struct {
      logic signed [CW-1:0] sx, sy, ex, ey, rad;
   } arc_cmd_type;

   typedef struct {
      logic signed [CW-1:0] cx, cy;
      logic                 found;
   } center_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic signed [CW-1:0] req_start_x = 0, req_start_y = 0, req_end_x = 0, req_end_y = 0;
   logic signed [CW-1:0] req_radius = 0;
   logic rsp_valid, rsp_ready = 0, rsp_found;
   logic signed [CW-1:0] rsp_center_x, rsp_center_y;

   arc_cmd_type cmd_queue[$];
   center_type  centers_due[$];
   int       errors = 0;
   int       sent = 0;
   int       req_gap = 0, rsp_gap = 0;
   bit       hold_done = 0, holding = 0;

   arc_center_from_radius #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [127:0] floor_sqrt(logic [127:0] n);
      logic [127:0] res, bt, t;
      res = 0;
      bt = 128'd1 << 126;
      while (bt != 0 && n < bt) bt = bt >> 2;
      while (bt != 0) begin
         t = res + bt;
         if (n >= t) begin
            n = n - t;
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic longint doubled_offset(longint c, logic [127:0] q, logic [127:0] p);
      logic [127:0] mc, m;
      mc = (c < 0) ? -c : c;
      m = (((mc * q) << 1) + p) / (p << 1);
      return (c < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [CW-1:0] clamp(longint v);
      if (v > CMAX) v = CMAX;
      if (v < CMIN) v = CMIN;
      return v[CW-1:0];
   endfunction

   function automatic center_type predict_center(arc_cmd_type c);
      center_type o;
      longint x1, y1, x2, y2, r, a, b, ox2, oy2, vx, vy;
      logic [127:0] ma, mb, mr, chord_sq, r4, q, p;
      x1 = c.sx; y1 = c.sy; x2 = c.ex; y2 = c.ey; r = c.rad;
      a = y1 - y2;
      b = x2 - x1;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      mr = (r < 0) ? -r : r;
      chord_sq = ma * ma + mb * mb;
      r4 = (mr * mr) << 2;
      o.cx = 0;
      o.cy = 0;
      o.found = 0;
      if (chord_sq < CHORD_MIN || r4 < chord_sq) return o;
      q = floor_sqrt(r4 - chord_sq);
      p = floor_sqrt(chord_sq);
      ox2 = doubled_offset(a, q, p);
      oy2 = doubled_offset(b, q, p);
      if (r > 0) begin
         ox2 = -ox2;
         oy2 = -oy2;
      end
      vx = (x1 + x2 + ox2 + 1) >>> 1;
      vy = (y1 + y2 + oy2 + 1) >>> 1;
      o.cx = clamp(vx);
      o.cy = clamp(vy);
      o.found = 1;
      return o;
   endfunction

   function automatic arc_cmd_type mk(int sx, int sy, int ex, int ey, int rad);
      arc_cmd_type c;
      c.sx = sx; c.sy = sy; c.ex = ex; c.ey = ey; c.rad = rad;
      return c;
   endfunction

   function automatic arc_cmd_type random_cmd();
      arc_cmd_type c;
      logic signed [CW-1:0] dx, dy, rm;
      c.sx = $urandom;
      c.sy = $urandom;
      if ($urandom_range(0, 9) < 7) begin
         dx = $signed($urandom) >>> $urandom_range(4, 31);
         dy = $signed($urandom) >>> $urandom_range(4, 31);
         c.ex = c.sx + dx;
         c.ey = c.sy + dy;
         rm = $urandom >> $urandom_range(1, 24);
         c.rad = $urandom_range(0, 1) ? rm : -rm;
      end else begin
         c.ex = $urandom;
         c.ey = $urandom;
         c.rad = $urandom;
      end
      return c;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            centers_due.push_back(predict_center(mk(req_start_x, req_start_y, req_end_x,
                                                    req_end_y, req_radius)));
            sent++;
         end
         if (!hold_done && sent == 400) holding = 1;
         if (holding && centers_due.size() == 0 && !(req_valid && !req_ready)) begin
            holding = 0;
            hold_done = 1;
         end
         if (!req_valid || req_ready) begin
            if (holding) begin
               req_valid <= 0;
            end else if (req_gap > 0) begin
               req_gap--;
               req_valid <= 0;
            end else if (cmd_queue.size() > 0) begin
               arc_cmd_type c;
               c = cmd_queue.pop_front();
               req_valid <= 1;
               req_start_x <= c.sx;
               req_start_y <= c.sy;
               req_end_x <= c.ex;
               req_end_y <= c.ey;
               req_radius <= c.rad;
               if (cmd_queue.size() > 100 && $urandom_range(0, 7) == 0)
                  req_gap = $urandom_range(1, 16);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // result monitor and ready driver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (centers_due.size() == 0) begin
               $error("unexpected transfer on rsp channel");
               errors++;
            end else begin
               center_type e;
               e = centers_due.pop_front();
               if (rsp_center_x !== e.cx) begin
                  $error("center_x expected %0d actual %0d", e.cx, rsp_center_x);
                  errors++;
               end
               if (rsp_center_y !== e.cy) begin
                  $error("center_y expected %0d actual %0d", e.cy, rsp_center_y);
                  errors++;
               end
               if (rsp_found !== e.found) begin
                  $error("found expected %0d actual %0d", e.found, rsp_found);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 0;
         end else if (cmd_queue.size() > 100 && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 15);
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   initial begin
      // zero chord, zero radius, half-chord radius, threshold edges, extremes
      cmd_queue.push_back(mk(0, 0, 0, 0, 0));
      cmd_queue.push_back(mk(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000));
      cmd_queue.push_back(mk(0, 0, 32'h20000, 0, 0));
      cmd_queue.push_back(mk(0, 0, 32'h20000, 0, 32'h10000));
      cmd_queue.push_back(mk(0, 0, 32'h20000, 0, -32'h10000));
      cmd_queue.push_back(mk(0, 0, 32'h20000, 0, 32'hffff));
      cmd_queue.push_back(mk(0, 1310, 0, 0, 32'h10000));
      cmd_queue.push_back(mk(0, 1311, 0, 0, 32'h10000));
      cmd_queue.push_back(mk(0, 1311, 0, 0, -32'h10000));
      cmd_queue.push_back(mk(0, 0, 32'h30000, 32'h40000, 32'h50000));
      cmd_queue.push_back(mk(0, 0, 32'h30000, 32'h40000, -32'h50000));
      cmd_queue.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                             32'h7fffffff));
      cmd_queue.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                             32'h80000000));
      cmd_queue.push_back(mk(32'h7fff0000, 32'h7fff0000, 32'h7fff1000, 32'h7fff0000,
                             32'h7fffffff));
      cmd_queue.push_back(mk(32'h80000000, 32'h80000000, 32'h80001000, 32'h80000000,
                             32'h80000001));
      cmd_queue.push_back(mk(32'h7fffffff, 0, 32'h7ffffff0, 0, 32'h80000000));
      cmd_queue.push_back(mk(-32'h10000, -32'h10000, 32'h10000, 32'h10000, 32'h80000000));
      cmd_queue.push_back(mk(32'hffffffff, 32'hffffffff, 0, 0, 32'hffffffff));
      for (int i = 0; i < 850; i++) cmd_queue.push_back(random_cmd());
      repeat (4) @(posedge clock);
      reset <= 0;
      wait (cmd_queue.size() == 0 && !req_valid && centers_due.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0 && centers_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
